### rtl/core/skne_pkg.sv
`default_nettype none

package skne_pkg;

	// width of the reported value, two's complement
	localparam int NUMBER_BITS = 32;
	localparam int MAG_BITS    = NUMBER_BITS - 1;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [3:0] RADIX    = 4'd10;

	localparam logic [2:0] QUOTED_KEY_LEN = 3'd7;
	localparam logic [2:0] BARE_KEY_LEN   = 3'd5;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'd0,
		PH_COLON  = 3'd1,
		PH_SKIP   = 3'd2,
		PH_SIGNED = 3'd3,
		PH_DIGITS = 3'd4,
		PH_DONE   = 3'd5,
		PH_FAILED = 3'd6
	} skne_phase_t;

	typedef struct packed {
		skne_phase_t phase;
		logic        negative;
	} skne_trk_status_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       is_last;
	} skne_in_t;

	typedef struct packed {
		logic                          found;
		logic signed [NUMBER_BITS-1:0] angle_value;
	} skne_out_t;

	// key character at a given position; the quoted key wraps servo in double quotes
	function automatic logic [7:0] key_char(input logic quoted, input logic [2:0] idx);
		logic [2:0] pos;
		logic [7:0] ch;
		begin
			pos = quoted ? idx : idx + 3'd1;
			unique case (pos)
				3'd0: ch = CH_QUOTE;
				3'd1: ch = 8'h73;
				3'd2: ch = 8'h65;
				3'd3: ch = 8'h72;
				3'd4: ch = 8'h76;
				3'd5: ch = 8'h6f;
				3'd6: ch = CH_QUOTE;
				default: ch = CH_NUL;
			endcase
			return ch;
		end
	endfunction

endpackage

`default_nettype wire

### rtl/core/skne_tracker.sv
`default_nettype none

module skne_tracker #(
	parameter bit QUOTED = 1'b0
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [7:0]                char_byte,
	input  wire logic                      upd,
	input  wire logic                      commit,
	input  wire logic                      clr,
	output skne_pkg::skne_trk_status_t     status,
	output logic [skne_pkg::MAG_BITS-1:0]  magnitude
);
	import skne_pkg::*;

	localparam logic [2:0] KEY_LEN = QUOTED ? QUOTED_KEY_LEN : BARE_KEY_LEN;
	localparam logic [NUMBER_BITS+2:0] SAT_LIMIT = {4'b0, {MAG_BITS{1'b1}}};

	logic [2:0]          prog_q, prog_nxt;
	skne_trk_status_t    stat_q, stat_nxt;
	logic [MAG_BITS-1:0] mag_q, mag_nxt;
	logic                is_digit;
	logic [3:0]          digit;
	logic [MAG_BITS-1:0] acc_base;
	logic [NUMBER_BITS+2:0] acc_wide;
	logic [MAG_BITS-1:0] acc_sat;

	assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
	assign digit    = 4'(char_byte - CH_ZERO);
	assign acc_base = (stat_q.phase == PH_DIGITS) ? mag_q : '0;

	// times ten plus digit, saturating at the largest magnitude
	always_comb begin
		acc_wide = ({4'b0, acc_base} << 3) + ({4'b0, acc_base} << 1)
			+ (NUMBER_BITS+3)'(digit);
		acc_sat  = (acc_wide > SAT_LIMIT) ? {MAG_BITS{1'b1}} : acc_wide[MAG_BITS-1:0];
	end

	always_comb begin
		prog_nxt = prog_q;
		stat_nxt = stat_q;
		mag_nxt  = mag_q;
		unique case (stat_q.phase)
			PH_SEARCH: begin
				if (prog_q < KEY_LEN && char_byte == key_char(QUOTED, prog_q)) begin
					prog_nxt = prog_q + 3'd1;
					if (prog_nxt == KEY_LEN) begin
						stat_nxt.phase = PH_COLON;
					end
				end else begin
					prog_nxt = (char_byte == key_char(QUOTED, 3'd0)) ? 3'd1 : 3'd0;
				end
			end
			PH_COLON: begin
				if (char_byte == CH_COLON) begin
					stat_nxt.phase = PH_SKIP;
				end
			end
			PH_SKIP: begin
				priority if (char_byte == CH_SPACE || char_byte == CH_QUOTE
						|| char_byte == CH_TAB || char_byte == CH_CR
						|| char_byte == CH_LF) begin
					stat_nxt.phase = PH_SKIP;
				end else if (char_byte == CH_MINUS) begin
					stat_nxt.negative = 1'b1;
					stat_nxt.phase    = PH_SIGNED;
				end else if (char_byte == CH_PLUS) begin
					stat_nxt.phase = PH_SIGNED;
				end else if (is_digit) begin
					mag_nxt        = acc_sat;
					stat_nxt.phase = PH_DIGITS;
				end else begin
					stat_nxt.phase = PH_FAILED;
				end
			end
			PH_SIGNED: begin
				if (is_digit) begin
					mag_nxt        = acc_sat;
					stat_nxt.phase = PH_DIGITS;
				end else begin
					stat_nxt.phase = PH_FAILED;
				end
			end
			PH_DIGITS: begin
				if (is_digit) begin
					mag_nxt = acc_sat;
				end else begin
					stat_nxt.phase = PH_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	// view after this byte, used for the report on the closing byte
	assign status    = upd ? stat_nxt : stat_q;
	assign magnitude = upd ? mag_nxt : mag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_q          <= '0;
			stat_q.phase    <= PH_SEARCH;
			stat_q.negative <= 1'b0;
			mag_q           <= '0;
		end else if (clr) begin
			prog_q          <= '0;
			stat_q.phase    <= PH_SEARCH;
			stat_q.negative <= 1'b0;
			mag_q           <= '0;
		end else if (commit && upd) begin
			prog_q <= prog_nxt;
			stat_q <= stat_nxt;
			mag_q  <= mag_nxt;
		end
	end

endmodule

`default_nettype wire

### rtl/core/servo_key_number_extractor.sv
`default_nettype none

// Servo key number extractor. Feed a text message one byte per request on the
// in channel; is_last marks the final byte. Two trackers watch the stream: one
// for the first "servo" in double quotes, one for the first bare servo. After
// its key a tracker waits for a colon, skips spaces, tabs, CR, LF and double
// quotes, takes an optional sign and gathers decimal digits, saturating the
// magnitude at 2^31-1. One request comes out per message: on the byte marked
// last, or on a zero byte, which is not parsed and after which the rest of the
// message up to the last byte is dropped. The quoted tracker decides the result
// whenever its key was seen, with no fall-back to the bare one. found is 0 and
// angle_value is 0 when no digit followed the chosen key. Throughput is one
// byte per clock while no closing byte waits on the output. A result reaches
// the out channel through the input register, which holds the closing byte,
// and the result register, which the tracker update that byte drives feeds.
// Back-pressure on out stalls input only when a byte that closes a message
// meets a result that has not been taken yet.
module servo_key_number_extractor (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire skne_pkg::skne_in_t  in_data,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output skne_pkg::skne_out_t  out_data
);
	import skne_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	// message state
	logic ended_q;

	// result register
	logic      out_valid_q;
	skne_out_t out_data_q;

	logic work;
	logic produce;
	logic advance;
	logic clr;

	skne_trk_status_t    q_stat, b_stat, sel_stat;
	logic [MAG_BITS-1:0] q_mag, b_mag, sel_mag;
	logic                rep_found;
	logic [NUMBER_BITS-1:0] rep_value;

	// a zero byte ends the string and is not parsed
	assign work    = valid_s1 && !ended_q && (byte_s1 != CH_NUL);
	assign produce = valid_s1 && !ended_q && ((byte_s1 == CH_NUL) || last_s1);
	// only a byte that yields a result waits on the output register
	assign advance = valid_s1 && (!produce || !out_valid_q || out_ready);
	assign clr     = advance && last_s1;

	assign in_ready = !valid_s1 || advance;

	skne_tracker #(.QUOTED(1'b1)) u_quoted (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_byte (byte_s1),
		.upd       (work),
		.commit    (advance),
		.clr       (clr),
		.status    (q_stat),
		.magnitude (q_mag)
	);

	skne_tracker #(.QUOTED(1'b0)) u_bare (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_byte (byte_s1),
		.upd       (work),
		.commit    (advance),
		.clr       (clr),
		.status    (b_stat),
		.magnitude (b_mag)
	);

	// quoted tracker wins once its key has been seen
	always_comb begin
		if (q_stat.phase != PH_SEARCH) begin
			sel_stat = q_stat;
			sel_mag  = q_mag;
		end else begin
			sel_stat = b_stat;
			sel_mag  = b_mag;
		end
		rep_found = (sel_stat.phase == PH_DIGITS) || (sel_stat.phase == PH_DONE);
		if (!rep_found) begin
			rep_value = '0;
		end else if (sel_stat.negative) begin
			rep_value = -{1'b0, sel_mag};
		end else begin
			rep_value = {1'b0, sel_mag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_data.char_byte;
			last_s1 <= in_data.is_last;
		end
	end

	// bytes after a zero byte are dropped until the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ended_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				ended_q <= 1'b0;
			end else if (!ended_q && byte_s1 == CH_NUL) begin
				ended_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && produce) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			out_data_q.found       <= rep_found;
			out_data_q.angle_value <= rep_value;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

### dv/servo_value_checker.sv
`timescale 1ns / 100ps

module servo_value_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_ready,
	input  wire skne_pkg::skne_in_t  in_data,
	input  wire logic                out_valid,
	input  wire logic                out_ready,
	input  wire skne_pkg::skne_out_t out_data,
	output int                       fail_count,
	output int                       pending,
	output int                       results_seen,
	output int                       numbers_seen
);

	import skne_pkg::*;

	localparam logic [55:0]     QUOTED_KEY = {CH_QUOTE, "servo", CH_QUOTE};
	localparam logic [39:0]     BARE_KEY   = "servo";
	localparam longint unsigned MAG_LIMIT  = (64'd1 << MAG_BITS) - 1;

	typedef struct packed {
		logic [2:0]          matched;
		skne_phase_t         phase;
		logic                negative;
		logic [MAG_BITS-1:0] magnitude;
	} tracker_t;

	tracker_t  quoted_trk;
	tracker_t  bare_trk;
	logic      message_closed;
	skne_out_t expected_angles[$];
	skne_out_t want;
	int        errors;
	int        results;
	int        numbers;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	// saturating decimal accumulate
	function automatic logic [MAG_BITS-1:0] append_digit(input logic [MAG_BITS-1:0] mag,
			input logic [7:0] c);
		longint unsigned d;
		longint unsigned wide;
		d = 64'(c - CH_ZERO);
		wide = 64'(mag);
		if (wide > (MAG_LIMIT - d) / 10)
			return MAG_BITS'(MAG_LIMIT);
		return MAG_BITS'(wide * 10 + d);
	endfunction

	function automatic tracker_t advance_tracker(input tracker_t t, input logic [7:0] c,
			input logic quoted);
		tracker_t   n;
		logic [2:0] key_len;
		logic [7:0] key_ch;
		logic [7:0] key_first;
		n = t;
		key_len = quoted ? QUOTED_KEY_LEN : BARE_KEY_LEN;
		key_first = quoted ? CH_QUOTE : BARE_KEY[39 -: 8];
		if (t.matched < key_len)
			key_ch = quoted ? QUOTED_KEY[55 - 8 * t.matched -: 8]
				: BARE_KEY[39 - 8 * t.matched -: 8];
		else
			key_ch = CH_NUL;
		case (t.phase)
			PH_SEARCH: begin
				// a miss restarts at one only when the byte opens the key again
				if (t.matched < key_len && c == key_ch) begin
					n.matched = t.matched + 3'd1;
					if (n.matched == key_len)
						n.phase = PH_COLON;
				end else begin
					n.matched = (c == key_first) ? 3'd1 : 3'd0;
				end
			end
			PH_COLON: begin
				if (c == CH_COLON)
					n.phase = PH_SKIP;
			end
			PH_SKIP: begin
				if (c == CH_MINUS) begin
					n.negative = 1'b1;
					n.phase = PH_SIGNED;
				end else if (c == CH_PLUS) begin
					n.phase = PH_SIGNED;
				end else if (is_digit(c)) begin
					n.magnitude = append_digit('0, c);
					n.phase = PH_DIGITS;
				end else if (!(c == CH_SPACE || c == CH_QUOTE || c == CH_TAB ||
						c == CH_CR || c == CH_LF)) begin
					n.phase = PH_FAILED;
				end
			end
			PH_SIGNED: begin
				if (is_digit(c)) begin
					n.magnitude = append_digit('0, c);
					n.phase = PH_DIGITS;
				end else begin
					n.phase = PH_FAILED;
				end
			end
			PH_DIGITS: begin
				if (is_digit(c))
					n.magnitude = append_digit(t.magnitude, c);
				else
					n.phase = PH_DONE;
			end
			default: begin
			end
		endcase
		return n;
	endfunction

	// quoted key wins whenever it was seen
	function automatic skne_out_t closing_result(input tracker_t q, input tracker_t b);
		tracker_t  pick;
		skne_out_t r;
		pick = (q.phase != PH_SEARCH) ? q : b;
		r = '0;
		if (pick.phase == PH_DIGITS || pick.phase == PH_DONE) begin
			r.found = 1'b1;
			r.angle_value = pick.negative ? -$signed({1'b0, pick.magnitude})
				: $signed({1'b0, pick.magnitude});
		end
		return r;
	endfunction

	task automatic clear_trackers();
		quoted_trk = '0;
		quoted_trk.phase = PH_SEARCH;
		bare_trk = '0;
		bare_trk.phase = PH_SEARCH;
		message_closed = 1'b0;
	endtask

	task automatic close_message();
		expected_angles.push_back(closing_result(quoted_trk, bare_trk));
		if (expected_angles[$].found)
			numbers++;
	endtask

	initial begin
		errors = 0;
		results = 0;
		numbers = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_trackers();
			expected_angles.delete();
		end else begin
			if (in_valid && in_ready) begin
				if (message_closed) begin
					if (in_data.is_last)
						clear_trackers();
				end else if (in_data.char_byte == CH_NUL) begin
					close_message();
					if (in_data.is_last)
						clear_trackers();
					else
						message_closed = 1'b1;
				end else begin
					quoted_trk = advance_tracker(quoted_trk, in_data.char_byte, 1'b1);
					bare_trk = advance_tracker(bare_trk, in_data.char_byte, 1'b0);
					if (in_data.is_last) begin
						close_message();
						clear_trackers();
					end
				end
			end
			if (out_valid && out_ready) begin
				results++;
				if (expected_angles.size() == 0) begin
					$display("%0t: result with nothing expected, found %0b value %0d",
						$time, out_data.found, out_data.angle_value);
					errors++;
				end else begin
					want = expected_angles.pop_front();
					if (out_data.found !== want.found) begin
						$display("%0t: found mismatch, expected %0b, got %0b",
							$time, want.found, out_data.found);
						errors++;
					end
					if (out_data.angle_value !== want.angle_value) begin
						$display("%0t: angle_value mismatch, expected %0d, got %0d",
							$time, want.angle_value, out_data.angle_value);
						errors++;
					end
				end
			end
		end
		fail_count <= errors;
		pending <= expected_angles.size();
		results_seen <= results;
		numbers_seen <= numbers;
	end

endmodule

### dv/tb_servo_key_number_extractor.sv
`timescale 1ns / 100ps

module tb_servo_key_number_extractor;

	import skne_pkg::*;

	localparam int RANDOM_BYTES = 1300;
	// cycles with no request moving on either side before the run is given up
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 8;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	skne_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	skne_out_t out_data;

	int fail_count;
	int pending;
	int results_seen;
	int numbers_seen;

	int idle_pct;
	int stall_pct;
	int bytes_sent;
	int messages_sent;
	int quiet_cycles;

	// bytes of the message being built, sent in order with is_last on the final one
	logic [7:0] msg[$];

	servo_key_number_extractor dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	// watches both channels, predicts every result and scores it
	servo_value_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.fail_count  (fail_count),
		.pending     (pending),
		.results_seen(results_seen),
		.numbers_seen(numbers_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side back-pressure, redrawn every cycle
	always @(posedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// watchdog: any accepted request on either side restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no request moved for %0d cycles, %0d results outstanding",
					$time, QUIET_LIMIT, pending);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	function automatic logic [7:0] noise_byte();
		// never zero, so noise cannot end the string by accident
		return 8'($urandom_range(1, 255));
	endfunction

	task automatic queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			msg.push_back(s[i]);
	endtask

	// present one byte; valid only drops when an idle gap is drawn, so it is
	// never lowered and raised again in the same step
	task automatic offer_byte(input logic [7:0] b, input logic last);
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(0, 99) < idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data.char_byte <= b;
		in_data.is_last <= last;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_message();
		for (int i = 0; i < msg.size(); i++)
			offer_byte(msg[i], i == msg.size() - 1);
		bytes_sent += msg.size();
		messages_sent++;
		msg.delete();
	endtask

	// mostly well-formed key/colon/number messages with random content, plus
	// broken keys, junk before the digits, zero-terminated strings and noise
	task automatic compose_message();
		int key_form;
		int sign_form;
		int digit_form;
		int tail_form;
		repeat ($urandom_range(0, 3))
			msg.push_back(noise_byte());
		key_form = $urandom_range(0, 99);
		if (key_form < 35) begin
			queue_text("\"servo\"");
		end else if (key_form < 65) begin
			queue_text("servo");
		end else if (key_form < 75) begin
			// bare first, quoted later: the quoted one still decides
			queue_text("servo");
			repeat ($urandom_range(0, 4))
				msg.push_back(noise_byte());
			queue_text("\"servo\"");
		end else if (key_form < 83) begin
			// restart on a repeated opening character
			if ($urandom_range(0, 1))
				queue_text("sservo");
			else
				queue_text("\"\"servo\"");
		end else if (key_form < 92) begin
			// key cut short
			if ($urandom_range(0, 1))
				queue_text("serv");
			else
				queue_text("\"serv");
			msg.push_back(noise_byte());
		end
		if ($urandom_range(0, 99) < 25) begin
			repeat ($urandom_range(1, 3))
				msg.push_back(noise_byte());
		end
		if ($urandom_range(0, 99) < 90)
			msg.push_back(CH_COLON);
		if ($urandom_range(0, 99) < 8)
			msg.push_back(noise_byte());
		repeat ($urandom_range(0, 3)) begin
			case ($urandom_range(0, 4))
				0: msg.push_back(CH_SPACE);
				1: msg.push_back(CH_QUOTE);
				2: msg.push_back(CH_TAB);
				3: msg.push_back(CH_CR);
				default: msg.push_back(CH_LF);
			endcase
		end
		sign_form = $urandom_range(0, 9);
		if (sign_form < 3)
			msg.push_back(CH_MINUS);
		else if (sign_form < 5)
			msg.push_back(CH_PLUS);
		digit_form = $urandom_range(0, 99);
		if (digit_form < 10) begin
			// long numbers around and past the saturation point
			case ($urandom_range(0, 3))
				0: queue_text("2147483647");
				1: queue_text("2147483648");
				2: begin
					repeat ($urandom_range(10, 14))
						msg.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
				end
				default: queue_text("99999999999999");
			endcase
		end else if (digit_form < 92) begin
			repeat ($urandom_range(1, 6))
				msg.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
		end
		tail_form = $urandom_range(0, 99);
		if (tail_form >= 40 && tail_form < 70) begin
			msg.push_back(CH_SPACE);
			repeat ($urandom_range(0, 4))
				msg.push_back(noise_byte());
		end else if (tail_form >= 70 && tail_form < 90) begin
			// zero byte, then bytes the block must drop (zero included)
			msg.push_back(CH_NUL);
			repeat ($urandom_range(0, 3))
				msg.push_back(8'($urandom_range(0, 255)));
		end else if (tail_form >= 90) begin
			repeat ($urandom_range(1, 5))
				msg.push_back(noise_byte());
		end
		if (msg.size() == 0)
			msg.push_back(noise_byte());
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		bytes_sent = 0;
		messages_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: bare key with a plus sign, number closed by the last byte
		queue_text("servo:+9");
		send_message();
		// empty message: a lone zero byte that is also the last
		msg.push_back(CH_NUL);
		send_message();
		// quoted key without a colon: no number and no fall-back to the bare
		// match; zero byte ends the string and high bytes after it are dropped
		queue_text("\"servo\"x");
		msg.push_back(CH_NUL);
		msg.push_back(8'hff);
		msg.push_back(8'h80);
		send_message();
		// sign with no digits after it
		queue_text("servo:-");
		send_message();

		// random messages over four pressure phases
		while (bytes_sent < RANDOM_BYTES) begin
			case (bytes_sent * 4 / RANDOM_BYTES)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 83;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 83;
				end
				default: begin
					idle_pct = 6;
					stall_pct = 6;
				end
			endcase
			compose_message();
			send_message();
		end
		in_valid <= 1'b0;

		// let the last closing byte reach the predictor, then drain
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d bytes in %0d messages across idle and stall phases",
			bytes_sent, messages_sent);
		$display("checked %0d results, %0d of them carrying a number",
			results_seen, numbers_seen);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### files.f
rtl/core/skne_pkg.sv
rtl/core/skne_tracker.sv
rtl/core/servo_key_number_extractor.sv
dv/servo_value_checker.sv
dv/tb_servo_key_number_extractor.sv
